// ===== sv/b58_pkg.sv =====
`timescale 1ns / 1ps

package b58_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned SYM_W       = 7;
  localparam int unsigned ACC_W       = DIGIT_W + BYTE_W;
  localparam int unsigned BASE        = 58;

  // Quotient by 58 as a multiply by a rounded-up reciprocal. It is exact for
  // every accumulator value up to 57 * 256 + 255.
  localparam int unsigned DIV58_MUL   = 18079;
  localparam int unsigned DIV58_SHIFT = 20;
  localparam int unsigned DIV58_MUL_W = 15;
  localparam int unsigned PROD_W      = ACC_W + DIV58_MUL_W;

  localparam logic [SYM_W-1:0] SYM_ONE = 7'd49;
  localparam logic [SYM_W-1:0] SYM_ERR = 7'd0;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'b001,
    CELL_MAC   = 3'b010,
    CELL_SHIFT = 3'b100
  } cell_op_e;

  typedef struct packed {
    logic               tok;
    logic [BYTE_W-1:0]  carry;
    logic [DIGIT_W-1:0] digit;
  } link_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWEEP  = 6'b000010,
    ST_ALIGN  = 6'b000100,
    ST_PREFIX = 6'b001000,
    ST_DIGITS = 6'b010000,
    ST_ERROR  = 6'b100000
  } state_e;

  function automatic logic [BYTE_W-1:0] b58_div58(input logic [ACC_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(DIV58_MUL);
    return p[DIV58_SHIFT +: BYTE_W];
  endfunction

  // Maps a digit to its character; the alphabet skips 0, I, O and l.
  function automatic logic [SYM_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [SYM_W-1:0] dx;
    dx = SYM_W'(d);
    if (d < 6'd9) begin
      return dx + 7'd49;
    end else if (d < 6'd17) begin
      return dx + 7'd56;
    end else if (d < 6'd22) begin
      return dx + 7'd57;
    end else if (d < 6'd33) begin
      return dx + 7'd58;
    end else if (d < 6'd44) begin
      return dx + 7'd64;
    end else begin
      return dx + 7'd65;
    end
  endfunction

endpackage

// ===== sv/b58_if.sv =====
`timescale 1ns / 1ps

interface b58_byte_if;
  logic                           valid;
  logic                           ready;
  logic [b58_pkg::BYTE_W-1:0]     data_byte;
  logic                           final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b58_sym_if;
  logic                           valid;
  logic                           ready;
  logic [b58_pkg::SYM_W-1:0]      symbol;
  logic                           last_symbol;
  logic                           overflow;

  modport source (output valid, symbol, last_symbol, overflow, input ready);
  modport sink   (input valid, symbol, last_symbol, overflow, output ready);
endinterface

// ===== sv/b58_cell.sv =====
`timescale 1ns / 1ps

// One base-58 digit of the running value. A multiply-accumulate token walks
// up the row; during output the digits shift up one place per step.
module b58_cell #(
  parameter int unsigned CNT_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b58_pkg::cell_op_e op_i,
  input  logic [CNT_W-1:0]  count_i,
  input  b58_pkg::link_t    link_i,
  output b58_pkg::link_t    link_o,
  output logic              grow_o
);

  logic                          tok_q, tok_d;
  logic [b58_pkg::BYTE_W-1:0]    carry_q, carry_d;
  logic [b58_pkg::DIGIT_W-1:0]   digit_q, digit_d;
  logic                          live;
  logic [b58_pkg::DIGIT_W-1:0]   digit_eff;
  logic [b58_pkg::ACC_W-1:0]     acc;
  logic [b58_pkg::BYTE_W-1:0]    quo;
  logic [b58_pkg::ACC_W-1:0]     prod;
  logic [b58_pkg::ACC_W-1:0]     rem;

  // Cells at or above the digit count hold stale data and count as zero.
  assign live      = CNT_W'(IDX) < count_i;
  assign digit_eff = live ? digit_q : '0;
  assign acc       = {digit_eff, link_i.carry};
  assign quo       = b58_pkg::b58_div58(acc);
  assign prod      = b58_pkg::ACC_W'(quo) * b58_pkg::ACC_W'(b58_pkg::BASE);
  assign rem       = acc - prod;

  assign grow_o = (op_i == b58_pkg::CELL_MAC) && link_i.tok && !live &&
                  (link_i.carry != '0);

  always_comb begin
    tok_d   = 1'b0;
    carry_d = carry_q;
    digit_d = digit_q;
    unique case (op_i)
      b58_pkg::CELL_MAC: begin
        tok_d = link_i.tok;
        if (link_i.tok) begin
          digit_d = rem[b58_pkg::DIGIT_W-1:0];
          carry_d = quo;
        end
      end
      b58_pkg::CELL_SHIFT: begin
        digit_d = link_i.digit;
      end
      b58_pkg::CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    digit_q <= digit_d;
  end

  assign link_o.tok   = tok_q;
  assign link_o.carry = carry_q;
  assign link_o.digit = digit_q;

endmodule

// ===== sv/base58_encoder.sv =====
// Each accepted byte sends a token up the row of digit cells one cell per cycle, multiplying
// by 256 and adding the byte. Bytes past MAX_BYTES are dropped until the final byte.
// After the final byte the most significant digit is shifted up into the top cell, then one
// output word per cycle, while the output is not stalled, for the leading '1's and the digits;
// an overflowed message, or one of more than MAX_DIGITS words, gives one error word.
// Reset (rst_ni, asynchronous, active low) clears all message state; no clearing pass.
`timescale 1ns / 1ps

module base58_encoder #(
  parameter int unsigned MAX_BYTES  = 32,
  parameter int unsigned MAX_DIGITS = 44
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  b58_byte_if.sink   in_i,
  b58_sym_if.source  out_o
);

  // Counter widths follow from the two size limits.
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned PfxW = $clog2(MAX_BYTES + 1);
  localparam int unsigned TotW = ((CntW > PfxW) ? CntW : PfxW) + 1;

  b58_pkg::state_e                state_q, state_d;
  logic [b58_pkg::BYTE_W-1:0]     byte_q, byte_d;
  logic                           start_q, start_d;
  logic                           fin_q, fin_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [PfxW-1:0]                prefix_q, prefix_d;
  logic                           in_prefix_q, in_prefix_d;
  logic [PfxW-1:0]                byte_cnt_q, byte_cnt_d;
  logic                           ovf_q, ovf_d;
  logic [CntW-1:0]                cnt_q, cnt_d;

  logic                           out_valid_q, out_valid_d;
  logic [b58_pkg::SYM_W-1:0]      out_sym_q, out_sym_d;
  logic                           out_last_q, out_last_d;
  logic                           out_ovf_q, out_ovf_d;

  b58_pkg::cell_op_e              cell_op;
  b58_pkg::link_t                 link [MAX_DIGITS+1];
  logic [MAX_DIGITS-1:0]          grow;

  logic                           slot_free;
  logic                           sweep_done;
  logic                           ovf_next;
  logic [TotW-1:0]                total;
  logic                           bad_total;
  logic                           finish;

  // The row of cells: cell 0 takes the new byte as its carry and a zero as
  // the digit shifted in from below. The top cell supplies the most
  // significant digit during output and its carry shows a full store.
  assign link[0].tok   = start_q;
  assign link[0].carry = byte_q;
  assign link[0].digit = '0;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    b58_cell #(
      .CNT_W (CntW),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .count_i (count_q),
      .link_i  (link[g]),
      .link_o  (link[g+1]),
      .grow_o  (grow[g])
    );
  end

  // Input is taken only between bytes; the output register decouples the
  // two sides so a waiting word never stalls the byte sweep.
  assign in_i.ready = (state_q == b58_pkg::ST_IDLE);

  assign slot_free  = !out_valid_q || out_o.ready;
  assign sweep_done = link[MAX_DIGITS].tok;
  assign ovf_next   = ovf_q || (link[MAX_DIGITS].carry != '0);
  assign total      = TotW'(prefix_q) + TotW'(count_q);
  assign bad_total  = (total > TotW'(MAX_DIGITS)) || (total == '0);

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    start_d     = 1'b0;
    fin_d       = fin_q;
    count_d     = count_q;
    prefix_d    = prefix_q;
    in_prefix_d = in_prefix_q;
    byte_cnt_d  = byte_cnt_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    cell_op     = b58_pkg::CELL_HOLD;
    finish      = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // A new digit can only appear at the current top, so the count simply
    // steps up each time a cell reports growth.
    if (|grow) begin
      count_d = count_q + 1'b1;
    end

    unique case (state_q)
      b58_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          fin_d = in_i.final_byte;
          if (ovf_q || (byte_cnt_q >= PfxW'(MAX_BYTES))) begin
            // Once too long, bytes are only dropped until the final one.
            ovf_d = 1'b1;
            if (in_i.final_byte) begin
              state_d = b58_pkg::ST_ERROR;
            end
          end else begin
            byte_cnt_d = byte_cnt_q + 1'b1;
            if (in_prefix_q && (in_i.data_byte == '0)) begin
              prefix_d = prefix_q + 1'b1;
            end else begin
              in_prefix_d = 1'b0;
            end
            byte_d  = in_i.data_byte;
            start_d = 1'b1;
            state_d = b58_pkg::ST_SWEEP;
          end
        end
      end

      b58_pkg::ST_SWEEP: begin
        cell_op = b58_pkg::CELL_MAC;
        if (sweep_done) begin
          ovf_d = ovf_next;
          if (!fin_q) begin
            state_d = b58_pkg::ST_IDLE;
          end else if (ovf_next || bad_total) begin
            state_d = b58_pkg::ST_ERROR;
          end else begin
            state_d = b58_pkg::ST_ALIGN;
            cnt_d   = count_q;
          end
        end
      end

      // Shift the digits up until the most significant one sits in the top cell.
      b58_pkg::ST_ALIGN: begin
        if ((cnt_q == CntW'(MAX_DIGITS)) || (count_q == '0)) begin
          if (prefix_q != '0) begin
            state_d = b58_pkg::ST_PREFIX;
            cnt_d   = CntW'(prefix_q);
          end else begin
            state_d = b58_pkg::ST_DIGITS;
            cnt_d   = count_q;
          end
        end else begin
          cell_op = b58_pkg::CELL_SHIFT;
          cnt_d   = cnt_q + 1'b1;
        end
      end

      // One '1' for each leading zero byte.
      b58_pkg::ST_PREFIX: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = b58_pkg::SYM_ONE;
          out_last_d  = (cnt_q == CntW'(1)) && (count_q == '0);
          out_ovf_d   = 1'b0;
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            if (count_q == '0) begin
              finish = 1'b1;
            end else begin
              state_d = b58_pkg::ST_DIGITS;
              cnt_d   = count_q;
            end
          end
        end
      end

      // Digits leave from the top cell, most significant first.
      b58_pkg::ST_DIGITS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = b58_pkg::b58_char(link[MAX_DIGITS].digit);
          out_last_d  = (cnt_q == CntW'(1));
          out_ovf_d   = 1'b0;
          cell_op     = b58_pkg::CELL_SHIFT;
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            finish = 1'b1;
          end
        end
      end

      b58_pkg::ST_ERROR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = b58_pkg::SYM_ERR;
          out_last_d  = 1'b1;
          out_ovf_d   = 1'b1;
          finish      = 1'b1;
        end
      end

      default: begin
        state_d = b58_pkg::ST_IDLE;
      end
    endcase

    // The end of every message returns the message state to its reset values.
    if (finish) begin
      state_d     = b58_pkg::ST_IDLE;
      count_d     = '0;
      prefix_d    = '0;
      in_prefix_d = 1'b1;
      byte_cnt_d  = '0;
      ovf_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b58_pkg::ST_IDLE;
      start_q     <= 1'b0;
      fin_q       <= 1'b0;
      count_q     <= '0;
      prefix_q    <= '0;
      in_prefix_q <= 1'b1;
      byte_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      prefix_q    <= prefix_d;
      in_prefix_q <= in_prefix_d;
      byte_cnt_q  <= byte_cnt_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.symbol      = out_sym_q;
  assign out_o.last_symbol = out_last_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

// ===== sv/b58_checker.sv =====
`timescale 1ns / 1ps

module b58_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [b58_pkg::SYM_W-1:0]     symbol_i,
  input logic                          last_symbol_i,
  input logic                          overflow_i
);

  // The error word is a lone, final word with a zero symbol.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> last_symbol_i && (symbol_i == b58_pkg::SYM_ERR))
    else $error("error word malformed");

  // Every ordinary word is a character of the alphabet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !overflow_i |->
      ((symbol_i >= 7'd49) && (symbol_i <= 7'd57)) ||
      ((symbol_i >= 7'd65) && (symbol_i <= 7'd90) && (symbol_i != 7'd73) &&
       (symbol_i != 7'd79)) ||
      ((symbol_i >= 7'd97) && (symbol_i <= 7'd122) && (symbol_i != 7'd108)))
    else $error("symbol outside alphabet");

  // While a message is still being emitted no new byte is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_symbol_i |-> !in_ready_i)
    else $error("input taken during emission");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(symbol_i) &&
      $stable(last_symbol_i) && $stable(overflow_i))
    else $error("stalled output word changed");

endmodule

bind base58_encoder b58_checker u_b58_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .symbol_i      (out_o.symbol),
  .last_symbol_i (out_o.last_symbol),
  .overflow_i    (out_o.overflow)
);
